>>> rtl/bqmt_pkg.sv
package bqmt_pkg;

  // Number of cells in the row and width of one stored key.
  localparam int unsigned Depth = 16;
  localparam int unsigned KeyW  = 64;

  // Count holds 0..Depth, a cell index holds 0..Depth-1.
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_MOVE   = 2'd1,
    CMD_LIST   = 2'd2
  } bqmt_cmd_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_LISTED    = 3'd3,
    ST_EMPTY     = 3'd4
  } bqmt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_FIN,
    S_LIST
  } bqmt_state_e;

  // Per-cell control: shift takes the right neighbor's key, load takes the
  // shared load bus and wins over shift.
  typedef struct packed {
    logic shift;
    logic load;
  } bqmt_cell_ctl_t;

endpackage

>>> rtl/bqmt_cell.sv
module bqmt_cell
  import bqmt_pkg::*;
(
  input  logic             clk_i,
  input  bqmt_cell_ctl_t   ctl_i,
  input  logic [KeyW-1:0]  nbr_i,
  input  logic [KeyW-1:0]  load_i,
  output logic [KeyW-1:0]  key_o
);

  logic [KeyW-1:0] key_q;
  logic [KeyW-1:0] key_d;

  always_comb begin
    priority if (ctl_i.load) begin
      key_d = load_i;
    end else if (ctl_i.shift) begin
      key_d = nbr_i;
    end else begin
      key_d = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

>>> rtl/bqmt_ctrl.sv
module bqmt_ctrl
  import bqmt_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   cmd_i,
  input  logic [KeyW-1:0]              key_i,
  output logic                         busy_o,
  input  logic [KeyW-1:0]              head_i,
  output bqmt_cell_ctl_t [Depth-1:0]   ctl_o,
  output logic [KeyW-1:0]              load_o,
  output logic                         result_strobe_o,
  output logic [2:0]                   status_o,
  output logic [KeyW-1:0]              entry_key_o,
  output logic                         last_o
);

  bqmt_state_e     state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] wr_q, wr_d;
  logic            hit_q, hit_d;
  logic [KeyW-1:0] key_q, key_d;

  logic            strobe_q, strobe_d;
  bqmt_status_e    status_q, status_d;
  logic [KeyW-1:0] ekey_q, ekey_d;
  logic            last_q, last_d;

  logic             shift;
  logic [Depth-1:0] ld;
  logic [CntW-1:0]  tgt;

  // Slot behind the unprocessed part and the entries already kept.
  assign tgt = rem_q + wr_q - CntW'(1);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    wr_d     = wr_q;
    hit_d    = hit_q;
    key_d    = key_q;
    strobe_d = 1'b0;
    status_d = ST_DONE;
    ekey_d   = '0;
    last_d   = 1'b1;
    shift    = 1'b0;
    ld       = '0;
    load_o   = key_i;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (cmd_i)
            CMD_INSERT: begin
              strobe_d = 1'b1;
              if (count_q == CntW'(Depth)) begin
                status_d = ST_FULL;
              end else begin
                ld[count_q[IdxW-1:0]] = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            CMD_MOVE: begin
              key_d = key_i;
              if (count_q == '0) begin
                strobe_d = 1'b1;
                status_d = ST_NOT_FOUND;
              end else begin
                state_d = S_MOVE;
                rem_d   = count_q;
                wr_d    = '0;
                hit_d   = 1'b0;
              end
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                state_d = S_LIST;
                rem_d   = count_q;
                wr_d    = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MOVE: begin
        shift  = 1'b1;
        load_o = head_i;
        if (head_i == key_q) begin
          hit_d = 1'b1;
        end else begin
          ld[tgt[IdxW-1:0]] = 1'b1;
          wr_d = wr_q + CntW'(1);
        end
        rem_d = rem_q - CntW'(1);
        if (rem_q == CntW'(1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        strobe_d = 1'b1;
        load_o   = key_q;
        state_d  = S_IDLE;
        if (hit_q) begin
          ld[wr_q[IdxW-1:0]] = 1'b1;
          count_d = wr_q + CntW'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      S_LIST: begin
        shift    = 1'b1;
        load_o   = head_i;
        ld[tgt[IdxW-1:0]] = 1'b1;
        wr_d     = wr_q + CntW'(1);
        rem_d    = rem_q - CntW'(1);
        strobe_d = 1'b1;
        status_d = ST_LISTED;
        ekey_d   = head_i;
        last_d   = (rem_q == CntW'(1));
        if (rem_q == CntW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ctl_o[i].shift = shift;
      ctl_o[i].load  = ld[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    wr_q     <= wr_d;
    hit_q    <= hit_d;
    key_q    <= key_d;
    status_q <= status_d;
    ekey_q   <= ekey_d;
    last_q   <= last_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign result_strobe_o = strobe_q;
  assign status_o        = status_q;
  assign entry_key_o     = ekey_q;
  assign last_o          = last_q;

endmodule

>>> rtl/bounded_queue_move_to_tail.sv
// Channel   Direction  Handshake                    Payload
// command   in         start_i high, busy_o low     cmd_i, key_i
// result    out        result_strobe_o, one cycle   status_o, entry_key_o, last_o
//
// An insert is handled in the cycle in which it is taken, and its result
// shows in the next cycle. A list is taken, then passes each entry over the
// head in turn, and each result shows in the cycle after its entry passes
// the head. A move-to-tail passes its entries the same way, then has one
// more step to append the key, and its result shows in the cycle after that
// step. On an empty queue list and move-to-tail answer like an insert. The
// pace is set by the row of cells, which rotates by one position per cycle
// so that the head cell passes each entry once.
// Reset is asynchronous and active low; it empties the queue and clears the
// control state, while the stored keys themselves are left as they are.
// The receiver cannot stall: every result is valid for exactly one cycle.
module bounded_queue_move_to_tail
  import bqmt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [1:0]      cmd_i,
  input  logic [KeyW-1:0] key_i,
  output logic            result_strobe_o,
  output logic [2:0]      status_o,
  output logic [KeyW-1:0] entry_key_o,
  output logic            last_o
);

  // The queue lives in a row of cells with the head in cell zero. During a
  // list or move-to-tail the whole row shifts toward the head every cycle;
  // the key that falls out of the head cell is written back behind the
  // entries still waiting, unless a move-to-tail drops it as a match. After
  // one pass over the live entries the kept ones are back in order at the
  // front of the row.
  bqmt_cell_ctl_t [Depth-1:0] cell_ctl;
  logic [KeyW-1:0]            cell_key [Depth];
  logic [KeyW-1:0]            load_key;

  bqmt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .cmd_i           (cmd_i),
    .key_i           (key_i),
    .busy_o          (busy_o),
    .head_i          (cell_key[0]),
    .ctl_o           (cell_ctl),
    .load_o          (load_key),
    .result_strobe_o (result_strobe_o),
    .status_o        (status_o),
    .entry_key_o     (entry_key_o),
    .last_o          (last_o)
  );

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [KeyW-1:0] nbr;
    if (i == Depth - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_key[i+1];
    end
    bqmt_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl[i]),
      .nbr_i  (nbr),
      .load_i (load_key),
      .key_o  (cell_key[i])
    );
  end

  // The final result of a command leaves the block ready for the next one.
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_o |-> !busy_o)
    else $error("final result shown while still busy");

  // Only a listing produces results that are not the final one.
  a_multi_listed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !last_o |-> status_o == ST_LISTED)
    else $error("non-final result that is not a listed entry");

  // A key is reported only with a listed entry.
  a_key_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && status_o != ST_LISTED |-> entry_key_o == '0)
    else $error("nonzero key on a status result");

  // A command that leaves the queue busy after it is taken emits no result
  // in the cycle in which busy first rises.
  a_busy_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> !result_strobe_o)
    else $error("result emitted as a multi-cycle command started");

endmodule
